/* rtl/bir_pkg.sv */
// Shared types, widths and codes for the bilinear resize block.
// No dependencies; every other file but bir_ram imports this package.
`default_nettype none
package bir_pkg;
    localparam int CHANNELS           = 3;
    localparam int COORD_W            = 9;
    localparam int PIX_W              = 8;
    localparam int RGB_W              = CHANNELS * PIX_W;
    localparam int DIM_W              = 10;
    localparam int STEP_W             = 25;
    localparam int FRAC_W             = 16;
    localparam int POS_W              = COORD_W + STEP_W;
    localparam int IPOS_W             = POS_W - FRAC_W;
    localparam int NWGT_W             = FRAC_W + 1;
    localparam int WGT_W              = 2 * FRAC_W + 1;
    localparam int ACC_W              = WGT_W + PIX_W;
    localparam int PADDR_W            = 4;
    localparam int PDATA_W            = 32;
    localparam int DEF_MAX_SRC_WIDTH  = 512;
    localparam int DEF_MAX_SRC_HEIGHT = 512;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_X_STEP     = 2'd2;
    localparam logic [1:0] REG_Y_STEP     = 2'd3;

    localparam logic [DIM_W-1:0]  RST_SRC_WIDTH  = 10'd512;
    localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT = 10'd512;
    localparam logic [STEP_W-1:0] RST_STEP       = 25'd65536;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   in_red;
        logic [PIX_W-1:0]   in_green;
        logic [PIX_W-1:0]   in_blue;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             index_clamped;
    } t_out_item;

    typedef struct packed {
        logic [WGT_W-1:0] w00;
        logic [WGT_W-1:0] w10;
        logic [WGT_W-1:0] w01;
        logic [WGT_W-1:0] w11;
    } t_wgts;

    // request state handed from address generation to the blend stages
    typedef struct packed {
        logic             vld;
        logic             cmd;
        logic             wr_ok;
        logic             bx;
        logic             clamp;
        logic [RGB_W-1:0] rgb;
        t_wgts            wgts;
    } t_meta;
endpackage
`default_nettype wire

/* rtl/bir_if.sv */
// Valid/ready stream interfaces for requests and results.
// Depends on bir_pkg for the payload types.
`default_nettype none
interface bir_in_if import bir_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bir_out_if import bir_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/bir_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule
`default_nettype wire

/* rtl/bir_cfg.sv */
// APB register file: source size and 9.16 steps, plus effective size.
// Depends on bir_pkg.
`default_nettype none
module bir_cfg import bir_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [PADDR_W-1:0]                    paddr,
    input  wire logic [PDATA_W-1:0]                    pwdata,
    output logic      [PDATA_W-1:0]                    prdata,
    output logic                                       pready,
    output logic      [$clog2(MAX_SRC_WIDTH+1)-1:0]    o_w,
    output logic      [$clog2(MAX_SRC_HEIGHT+1)-1:0]   o_h,
    output logic      [STEP_W-1:0]                     o_x_step,
    output logic      [STEP_W-1:0]                     o_y_step
);
    localparam int WW = $clog2(MAX_SRC_WIDTH + 1);
    localparam int HW = $clog2(MAX_SRC_HEIGHT + 1);

    logic [DIM_W-1:0]  r_src_width;
    logic [DIM_W-1:0]  r_src_height;
    logic [STEP_W-1:0] r_x_step;
    logic [STEP_W-1:0] r_y_step;
    logic              wr_acc;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_acc  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_x_step     <= RST_STEP;
            r_y_step     <= RST_STEP;
        end else if (wr_acc) begin
            case (reg_idx)
                REG_SRC_WIDTH:  r_src_width  <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= pwdata[DIM_W-1:0];
                REG_X_STEP:     r_x_step     <= pwdata[STEP_W-1:0];
                REG_Y_STEP:     r_y_step     <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(r_src_width);
            REG_SRC_HEIGHT: prdata = PDATA_W'(r_src_height);
            REG_X_STEP:     prdata = PDATA_W'(r_x_step);
            REG_Y_STEP:     prdata = PDATA_W'(r_y_step);
            default:        prdata = '0;
        endcase
    end

    // zero counts as one, oversize saturates at the store dimension
    always_comb begin
        if (r_src_width == '0) begin
            o_w = WW'(1);
        end else if (32'(r_src_width) > MAX_SRC_WIDTH) begin
            o_w = WW'(MAX_SRC_WIDTH);
        end else begin
            o_w = WW'(r_src_width);
        end
        if (r_src_height == '0) begin
            o_h = HW'(1);
        end else if (32'(r_src_height) > MAX_SRC_HEIGHT) begin
            o_h = HW'(MAX_SRC_HEIGHT);
        end else begin
            o_h = HW'(r_src_height);
        end
    end

    assign o_x_step = r_x_step;
    assign o_y_step = r_y_step;
endmodule
`default_nettype wire

/* rtl/bir_addr.sv */
// Address generation: position multiply, floor/ceil with clamping,
// row base multiply and neighbour addresses, four register stages.
// Depends on bir_pkg.
`default_nettype none
module bir_addr import bir_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_en,
    input  wire logic                                          i_vld,
    input  wire t_in_item                                      i_item,
    input  wire logic [$clog2(MAX_SRC_WIDTH+1)-1:0]            i_w,
    input  wire logic [$clog2(MAX_SRC_HEIGHT+1)-1:0]           i_h,
    input  wire logic [STEP_W-1:0]                             i_x_step,
    input  wire logic [STEP_W-1:0]                             i_y_step,
    output t_meta                                              o_meta,
    output logic [$clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT)-1:0]    o_addr_a,
    output logic [$clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT)-1:0]    o_addr_c
);
    localparam int WW = $clog2(MAX_SRC_WIDTH + 1);
    localparam int HW = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int PW = YW + WW;

    // stage 1
    logic               r1_vld;
    logic               r1_cmd;
    logic [COORD_W-1:0] r1_col;
    logic [COORD_W-1:0] r1_row;
    logic [RGB_W-1:0]   r1_rgb;
    logic [POS_W-1:0]   r1_px;
    logic [POS_W-1:0]   r1_py;
    // stage 2
    logic               r2_vld;
    logic               r2_cmd;
    logic               r2_wr_ok;
    logic               r2_clamp;
    logic [XW-1:0]      r2_xl;
    logic [XW-1:0]      r2_xh;
    logic [YW-1:0]      r2_yl;
    logic [YW-1:0]      r2_yh;
    logic [FRAC_W-1:0]  r2_wx;
    logic [FRAC_W-1:0]  r2_wy;
    logic [RGB_W-1:0]   r2_rgb;
    // stage 3
    logic               r3_vld;
    logic               r3_cmd;
    logic               r3_wr_ok;
    logic               r3_clamp;
    logic               r3_bx;
    logic [XW-1:0]      r3_xl;
    logic [AW-1:0]      r3_base_l;
    logic [AW-1:0]      r3_base_h;
    logic [RGB_W-1:0]   r3_rgb;
    t_wgts              r3_wgts;
    // stage 4
    t_meta              r4_meta;
    logic [AW-1:0]      r4_addr_a;
    logic [AW-1:0]      r4_addr_c;

    logic [IPOS_W-1:0]  xl0;
    logic [IPOS_W-1:0]  yl0;
    logic [IPOS_W:0]    xh0;
    logic [IPOS_W:0]    yh0;
    logic [31:0]        wmax;
    logic [31:0]        hmax;
    logic [XW-1:0]      n_xl;
    logic [XW-1:0]      n_xh;
    logic [YW-1:0]      n_yl;
    logic [YW-1:0]      n_yh;
    logic               n_clamp;
    logic               n_wr_ok;
    logic [NWGT_W-1:0]  nwx;
    logic [NWGT_W-1:0]  nwy;
    logic [PW-1:0]      prod_l;
    logic [PW-1:0]      prod_h;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
        end else if (i_en) begin
            r1_vld      <= i_vld;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
        end
    end

    // stage 1: source position in 18.16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd <= i_item.cmd;
            r1_col <= i_item.col;
            r1_row <= i_item.row;
            r1_rgb <= {i_item.in_red, i_item.in_green, i_item.in_blue};
            r1_px  <= POS_W'(i_item.col) * POS_W'(i_x_step);
            r1_py  <= POS_W'(i_item.row) * POS_W'(i_y_step);
        end
    end

    // stage 2: floor, ceiling, clamp
    assign xl0  = r1_px[POS_W-1:FRAC_W];
    assign yl0  = r1_py[POS_W-1:FRAC_W];
    assign xh0  = (IPOS_W+1)'(xl0) + (IPOS_W+1)'(r1_px[FRAC_W-1:0] != '0);
    assign yh0  = (IPOS_W+1)'(yl0) + (IPOS_W+1)'(r1_py[FRAC_W-1:0] != '0);
    assign wmax = 32'(i_w) - 32'd1;
    assign hmax = 32'(i_h) - 32'd1;

    always_comb begin
        n_clamp = 1'b0;
        n_wr_ok = (32'(r1_col) <= wmax) && (32'(r1_row) <= hmax);
        if (r1_cmd == CMD_WRITE) begin
            n_xl = XW'(r1_col);
            n_xh = XW'(r1_col);
            n_yl = YW'(r1_row);
            n_yh = YW'(r1_row);
        end else begin
            n_xl = XW'(xl0);
            n_xh = XW'(xh0);
            n_yl = YW'(yl0);
            n_yh = YW'(yh0);
            if (32'(xl0) > wmax) begin
                n_xl    = XW'(wmax);
                n_clamp = 1'b1;
            end
            if (32'(xh0) > wmax) begin
                n_xh    = XW'(wmax);
                n_clamp = 1'b1;
            end
            if (32'(yl0) > hmax) begin
                n_yl    = YW'(hmax);
                n_clamp = 1'b1;
            end
            if (32'(yh0) > hmax) begin
                n_yh    = YW'(hmax);
                n_clamp = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_cmd   <= r1_cmd;
            r2_wr_ok <= n_wr_ok;
            r2_clamp <= n_clamp;
            r2_xl    <= n_xl;
            r2_xh    <= n_xh;
            r2_yl    <= n_yl;
            r2_yh    <= n_yh;
            r2_wx    <= r1_px[FRAC_W-1:0];
            r2_wy    <= r1_py[FRAC_W-1:0];
            r2_rgb   <= r1_rgb;
        end
    end

    // stage 3: row bases and blend weights
    assign nwx    = NWGT_W'(1 << FRAC_W) - NWGT_W'(r2_wx);
    assign nwy    = NWGT_W'(1 << FRAC_W) - NWGT_W'(r2_wy);
    assign prod_l = PW'(r2_yl) * PW'(i_w);
    assign prod_h = PW'(r2_yh) * PW'(i_w);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_cmd       <= r2_cmd;
            r3_wr_ok     <= r2_wr_ok;
            r3_clamp     <= r2_clamp;
            r3_bx        <= r2_xh != r2_xl;
            r3_xl        <= r2_xl;
            r3_base_l    <= AW'(prod_l);
            r3_base_h    <= AW'(prod_h);
            r3_rgb       <= r2_rgb;
            r3_wgts.w00  <= WGT_W'(nwx) * WGT_W'(nwy);
            r3_wgts.w10  <= WGT_W'(r2_wx) * WGT_W'(nwy);
            r3_wgts.w01  <= WGT_W'(nwx) * WGT_W'(r2_wy);
            r3_wgts.w11  <= WGT_W'(r2_wx) * WGT_W'(r2_wy);
        end
    end

    // stage 4: top-left neighbour address in each row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_meta.vld <= 1'b0;
        end else if (i_en) begin
            r4_meta.vld <= r3_vld;
        end
        if (i_en) begin
            r4_meta.cmd   <= r3_cmd;
            r4_meta.wr_ok <= r3_wr_ok;
            r4_meta.bx    <= r3_bx;
            r4_meta.clamp <= r3_clamp;
            r4_meta.rgb   <= r3_rgb;
            r4_meta.wgts  <= r3_wgts;
            r4_addr_a     <= r3_base_l + AW'(r3_xl);
            r4_addr_c     <= r3_base_h + AW'(r3_xl);
        end
    end

    assign o_meta   = r4_meta;
    assign o_addr_a = r4_addr_a;
    assign o_addr_c = r4_addr_c;

    a_clamp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_vld && r2_cmd == CMD_COMPUTE) |->
            (32'(r2_xh) <= 32'(i_w) - 32'd1) && (32'(r2_yh) <= 32'(i_h) - 32'd1))
        else $error("neighbour index beyond source after clamp");

    a_ceil_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_vld && r2_cmd == CMD_COMPUTE) |->
            (r2_xh == r2_xl || 32'(r2_xh) == 32'(r2_xl) + 32'd1))
        else $error("ceiling column not adjacent to floor column");

    a_write_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_meta.vld && r4_meta.cmd == CMD_WRITE && r4_meta.wr_ok) |->
            (32'(r4_addr_a) < MAX_SRC_WIDTH * MAX_SRC_HEIGHT))
        else $error("write address beyond frame store");
endmodule
`default_nettype wire

/* rtl/bir_blend.sv */
// Blend stages: neighbour select, weighted products, sum and output register.
// Depends on bir_pkg and bir_out_if; also sets the pipeline advance.
`default_nettype none
module bir_blend import bir_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_meta            i_meta,
    input  wire logic             i_a_odd,
    input  wire logic             i_c_odd,
    input  wire logic [RGB_W-1:0] i_ae_data,
    input  wire logic [RGB_W-1:0] i_ao_data,
    input  wire logic [RGB_W-1:0] i_ce_data,
    input  wire logic [RGB_W-1:0] i_co_data,
    output logic                  o_en,
    bir_out_if.source             o_out
);
    logic             r5_vld;
    logic             r5_cmd;
    logic             r5_bx;
    logic             r5_clamp;
    t_wgts            r5_wgts;
    logic             r5_a_odd;
    logic             r5_c_odd;
    logic             r6_vld;
    logic             r6_cmd;
    logic             r6_clamp;
    logic [ACC_W-1:0] r6_p [CHANNELS][4];
    logic             r_out_vld;
    t_out_item        r_out;

    logic [RGB_W-1:0] px_a;
    logic [RGB_W-1:0] px_b;
    logic [RGB_W-1:0] px_c;
    logic [RGB_W-1:0] px_d;
    logic [ACC_W-1:0] sum [CHANNELS];
    logic [PIX_W-1:0] res [CHANNELS];

    // advance everything unless a finished result is held
    assign o_en = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld      <= 1'b0;
            r6_vld      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else if (o_en) begin
            r5_vld      <= i_meta.vld;
            r6_vld      <= r5_vld;
            r_out_vld   <= r6_vld && (r6_cmd == CMD_COMPUTE);
        end
    end

    // stage 5 lines up with the registered store read
    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r5_cmd        <= i_meta.cmd;
            r5_bx         <= i_meta.bx;
            r5_clamp      <= i_meta.clamp;
            r5_wgts       <= i_meta.wgts;
            r5_a_odd      <= i_a_odd;
            r5_c_odd      <= i_c_odd;
        end
    end

    always_comb begin
        px_a = r5_a_odd ? i_ao_data : i_ae_data;
        px_b = r5_bx ? (r5_a_odd ? i_ae_data : i_ao_data) : px_a;
        px_c = r5_c_odd ? i_co_data : i_ce_data;
        px_d = r5_bx ? (r5_c_odd ? i_ce_data : i_co_data) : px_c;
    end

    // stage 6: one product per neighbour and channel
    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r6_cmd   <= r5_cmd;
            r6_clamp <= r5_clamp;
            for (int k = 0; k < CHANNELS; k++) begin
                r6_p[k][0] <= ACC_W'(px_a[RGB_W-1-PIX_W*k -: PIX_W]) * ACC_W'(r5_wgts.w00);
                r6_p[k][1] <= ACC_W'(px_b[RGB_W-1-PIX_W*k -: PIX_W]) * ACC_W'(r5_wgts.w10);
                r6_p[k][2] <= ACC_W'(px_c[RGB_W-1-PIX_W*k -: PIX_W]) * ACC_W'(r5_wgts.w01);
                r6_p[k][3] <= ACC_W'(px_d[RGB_W-1-PIX_W*k -: PIX_W]) * ACC_W'(r5_wgts.w11);
            end
        end
    end

    // stage 7: sum and drop the 32 fraction bits
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            sum[k] = r6_p[k][0] + r6_p[k][1] + r6_p[k][2] + r6_p[k][3];
            res[k] = sum[k][2*FRAC_W +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_out.out_red       <= res[0];
            r_out.out_green     <= res[1];
            r_out.out_blue      <= res[2];
            r_out.index_clamped <= r6_clamp;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    a_weights_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r5_vld && r5_cmd == CMD_COMPUTE) |->
            ((WGT_W+2)'(r5_wgts.w00) + (WGT_W+2)'(r5_wgts.w10)
             + (WGT_W+2)'(r5_wgts.w01) + (WGT_W+2)'(r5_wgts.w11)
             == (WGT_W+2)'(64'd1 << (2*FRAC_W))))
        else $error("blend weights do not sum to one");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en |=> $stable(r6_vld) && $stable(r5_vld))
        else $error("pipeline moved while output stalled");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_en && r6_vld && r6_cmd == CMD_WRITE) |=> !r_out_vld)
        else $error("store write produced a result");
endmodule
`default_nettype wire

/* rtl/bilinear_image_resize.sv */
// Bilinear RGB resize engine.
// Usage: i_in carries requests. cmd=0 stores pixel (col,row) into the frame
// store at row*W+col (ignored outside the configured source). cmd=1 asks for
// destination pixel (col,row) and yields one result on o_out: four
// neighbours blended with 16-bit weights, truncated to 8 bits per channel,
// index_clamped set when a neighbour was held at the source edge.
// Configure size and 9.16 steps over APB only while no request is in flight.
// Throughput: one request per clock while the receiver does not stall. A result on
// o_out passes four address stages, the registered store read, one product stage
// and one sum stage into the output register.
// The store is two copies, each split into even and odd address banks, so the
// four neighbours come from four single-port RAM reads in the same cycle.
// Reset clears the pipeline valids and sets registers to their defaults; store
// contents stay undefined until written, with no clearing pass.
// When the receiver stalls, the whole pipeline holds and i_in.ready drops.
// Depends on bir_pkg, bir_if, bir_ram, bir_cfg, bir_addr, bir_blend.
`default_nettype none
module bilinear_image_resize import bir_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    bir_in_if.sink                  i_in,
    bir_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);
    localparam int WW  = $clog2(MAX_SRC_WIDTH + 1);
    localparam int HW  = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int AW  = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
    localparam int HAW = AW - 1;

    logic [WW-1:0]     src_w;
    logic [HW-1:0]     src_h;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
    logic              en;
    t_meta             meta;
    logic [AW-1:0]     addr_a;
    logic [AW-1:0]     addr_c;
    logic              wr;
    logic              rd_en;
    logic [HAW-1:0]    a_even;
    logic [HAW-1:0]    a_odd;
    logic [HAW-1:0]    c_even;
    logic [HAW-1:0]    c_odd;
    logic [HAW-1:0]    w_addr;
    logic [RGB_W-1:0]  ae_data;
    logic [RGB_W-1:0]  ao_data;
    logic [RGB_W-1:0]  ce_data;
    logic [RGB_W-1:0]  co_data;

    bir_cfg #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_w      (src_w),
        .o_h      (src_h),
        .o_x_step (x_step),
        .o_y_step (y_step)
    );

    assign i_in.ready = en;

    bir_addr #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_in.valid),
        .i_item   (i_in.data),
        .i_w      (src_w),
        .i_h      (src_h),
        .i_x_step (x_step),
        .i_y_step (y_step),
        .o_meta   (meta),
        .o_addr_a (addr_a),
        .o_addr_c (addr_c)
    );

    // even bank holds the even one of the pair (A, A+1), odd bank the other
    assign rd_en  = en & meta.vld;
    assign wr     = rd_en & (meta.cmd == CMD_WRITE) & meta.wr_ok;
    assign w_addr = addr_a[AW-1:1];
    assign a_even = addr_a[AW-1:1] + HAW'(addr_a[0]);
    assign a_odd  = addr_a[AW-1:1];
    assign c_even = addr_c[AW-1:1] + HAW'(addr_c[0]);
    assign c_odd  = addr_c[AW-1:1];

    bir_ram #(.WIDTH(RGB_W), .DEPTH(2 ** HAW)) u_ram_ae (
        .i_clk   (i_clk),
        .i_en    (rd_en),
        .i_we    (wr & ~addr_a[0]),
        .i_addr  (wr ? w_addr : a_even),
        .i_wdata (meta.rgb),
        .o_rdata (ae_data)
    );

    bir_ram #(.WIDTH(RGB_W), .DEPTH(2 ** HAW)) u_ram_ao (
        .i_clk   (i_clk),
        .i_en    (rd_en),
        .i_we    (wr & addr_a[0]),
        .i_addr  (wr ? w_addr : a_odd),
        .i_wdata (meta.rgb),
        .o_rdata (ao_data)
    );

    bir_ram #(.WIDTH(RGB_W), .DEPTH(2 ** HAW)) u_ram_ce (
        .i_clk   (i_clk),
        .i_en    (rd_en),
        .i_we    (wr & ~addr_a[0]),
        .i_addr  (wr ? w_addr : c_even),
        .i_wdata (meta.rgb),
        .o_rdata (ce_data)
    );

    bir_ram #(.WIDTH(RGB_W), .DEPTH(2 ** HAW)) u_ram_co (
        .i_clk   (i_clk),
        .i_en    (rd_en),
        .i_we    (wr & addr_a[0]),
        .i_addr  (wr ? w_addr : c_odd),
        .i_wdata (meta.rgb),
        .o_rdata (co_data)
    );

    bir_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_meta    (meta),
        .i_a_odd   (addr_a[0]),
        .i_c_odd   (addr_c[0]),
        .i_ae_data (ae_data),
        .i_ao_data (ao_data),
        .i_ce_data (ce_data),
        .i_co_data (co_data),
        .o_en      (en),
        .o_out     (o_out)
    );
endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the bilinear resize block: directed table and edge
// cases, then random load/compute traffic checked against an in-bench predictor.
// Depends on bir_pkg, bir_if and the bilinear_image_resize RTL.
`default_nettype none
module tb;
    import bir_pkg::*;

    localparam int MAXW = DEF_MAX_SRC_WIDTH;
    localparam int MAXH = DEF_MAX_SRC_HEIGHT;
    localparam int LATENCY = 7;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    bir_in_if  req_ch ();
    bir_out_if pix_ch ();

    bilinear_image_resize uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (pix_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [RGB_W-1:0]  img [MAXW*MAXH];
    bit                img_set [MAXW*MAXH];
    logic [DIM_W-1:0]  cfg_w, cfg_h;
    logic [STEP_W-1:0] cfg_xs, cfg_ys;
    t_out_item         pixel_q [$];
    int                n_errors;
    longint            cycle_cnt;
    bit                rx_stall_en;

    typedef struct {
        t_in_item   req;
        bit         has_exp;
        t_out_item  exp;
    } t_row;
    t_row dir_tab [$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_dim(logic [DIM_W-1:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic t_out_item blend_pixel(t_in_item r);
        t_out_item o;
        int w, h;
        longint px, py, wx, wy, xl, xh, yl, yh;
        longint a, b, c, d, w00, w10, w01, w11, sum;
        w = eff_dim(cfg_w, MAXW);
        h = eff_dim(cfg_h, MAXH);
        px = longint'(r.col) * longint'(cfg_xs);
        py = longint'(r.row) * longint'(cfg_ys);
        wx = px & 16'hFFFF;
        wy = py & 16'hFFFF;
        xl = px >> 16;
        yl = py >> 16;
        xh = xl + (wx != 0);
        yh = yl + (wy != 0);
        o.index_clamped = 1'b0;
        if (xl > w - 1) begin xl = w - 1; o.index_clamped = 1'b1; end
        if (xh > w - 1) begin xh = w - 1; o.index_clamped = 1'b1; end
        if (yl > h - 1) begin yl = h - 1; o.index_clamped = 1'b1; end
        if (yh > h - 1) begin yh = h - 1; o.index_clamped = 1'b1; end
        a = img[(yl * w + xl) % (MAXW*MAXH)];
        b = img[(yl * w + xh) % (MAXW*MAXH)];
        c = img[(yh * w + xl) % (MAXW*MAXH)];
        d = img[(yh * w + xh) % (MAXW*MAXH)];
        w00 = (65536 - wx) * (65536 - wy);
        w10 = wx * (65536 - wy);
        w01 = (65536 - wx) * wy;
        w11 = wx * wy;
        for (int k = 0; k < CHANNELS; k++) begin
            int sh;
            sh = 16 - 8 * k;
            sum = ((a >> sh) & 255) * w00 + ((b >> sh) & 255) * w10
                + ((c >> sh) & 255) * w01 + ((d >> sh) & 255) * w11;
            case (k)
                0: o.out_red   = 8'(sum >> 32);
                1: o.out_green = 8'(sum >> 32);
                default: o.out_blue = 8'(sum >> 32);
            endcase
        end
        return o;
    endfunction

    // all four neighbours of a compute were written under the current size
    function automatic bit neighbours_loaded(t_in_item r);
        int w, h;
        longint px, py, xl, xh, yl, yh;
        w = eff_dim(cfg_w, MAXW);
        h = eff_dim(cfg_h, MAXH);
        px = longint'(r.col) * longint'(cfg_xs);
        py = longint'(r.row) * longint'(cfg_ys);
        xl = px >> 16; yl = py >> 16;
        xh = xl + ((px & 16'hFFFF) != 0);
        yh = yl + ((py & 16'hFFFF) != 0);
        if (xl > w - 1) xl = w - 1;
        if (xh > w - 1) xh = w - 1;
        if (yl > h - 1) yl = h - 1;
        if (yh > h - 1) yh = h - 1;
        return img_set[(yl*w+xl) % (MAXW*MAXH)] && img_set[(yl*w+xh) % (MAXW*MAXH)]
            && img_set[(yh*w+xl) % (MAXW*MAXH)] && img_set[(yh*w+xh) % (MAXW*MAXH)];
    endfunction

    function automatic void apply_request(t_in_item r);
        int w, h;
        w = eff_dim(cfg_w, MAXW);
        h = eff_dim(cfg_h, MAXH);
        if (r.cmd == CMD_WRITE) begin
            if (r.col < w && r.row < h) begin
                img[r.row * w + r.col] = {r.in_red, r.in_green, r.in_blue};
                img_set[r.row * w + r.col] = 1'b1;
            end
        end else begin
            pixel_q.push_back(blend_pixel(r));
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        n_errors++;
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    t_out_item e;
                    e = pixel_q.pop_front();
                    if (pix_ch.data.out_red != e.out_red)
                        report_mismatch("red", pix_ch.data.out_red, e.out_red);
                    if (pix_ch.data.out_green != e.out_green)
                        report_mismatch("green", pix_ch.data.out_green, e.out_green);
                    if (pix_ch.data.out_blue != e.out_blue)
                        report_mismatch("blue", pix_ch.data.out_blue, e.out_blue);
                    if (pix_ch.data.index_clamped != e.index_clamped)
                        report_mismatch("clamp", pix_ch.data.index_clamped,
                                        e.index_clamped);
                end
            end
            pix_ch.ready <= rx_stall_en ? (($urandom_range(0, 3) != 0) ||
                                           (cycle_cnt[4:0] < 8)) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[bilinear_image_resize] ERROR");
            $finish;
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  cfg_w  = val[DIM_W-1:0];
            REG_SRC_HEIGHT: cfg_h  = val[DIM_W-1:0];
            REG_X_STEP:     cfg_xs = val[STEP_W-1:0];
            default:        cfg_ys = val[STEP_W-1:0];
        endcase
    endtask

    // bursty sender; holds valid across back-to-back requests
    int burst_left = 0;
    task automatic send_request(t_in_item r);
        while (burst_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        apply_request(r);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        while (pixel_q.size() != 0 && guard < 10000) begin
            @(posedge i_clk); guard++;
        end
        repeat (LATENCY + 3) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(logic cmd, int c, int r, int red, int grn, int blu);
        t_in_item t;
        t.cmd = cmd; t.col = 9'(c); t.row = 9'(r);
        t.in_red = 8'(red); t.in_green = 8'(grn); t.in_blue = 8'(blu);
        return t;
    endfunction

    function automatic t_out_item px_out(int red, int grn, int blu, bit cl);
        t_out_item o;
        o.out_red = 8'(red); o.out_green = 8'(grn); o.out_blue = 8'(blu);
        o.index_clamped = cl;
        return o;
    endfunction

    function automatic void add_row(t_in_item r, bit has, t_out_item o);
        t_row t;
        t.req = r; t.has_exp = has; t.exp = o;
        dir_tab.push_back(t);
    endfunction

    // fill a small image completely, then compute random pixels
    task automatic run_phase(int w, int h, int dw, int dh, int n_comp);
        int xs, ys, order [$];
        t_in_item r;
        drain();
        cfg_write(REG_SRC_WIDTH, 32'(w));
        cfg_write(REG_SRC_HEIGHT, 32'(h));
        xs = (dw <= 1) ? 0 : ((w - 1) * 65536) / (dw - 1);
        ys = (dh <= 1) ? 0 : ((h - 1) * 65536) / (dh - 1);
        if ($urandom_range(0, 4) == 0) xs = $urandom_range(0, 1 << 18);
        cfg_write(REG_X_STEP, 32'(xs));
        cfg_write(REG_Y_STEP, 32'(ys));
        for (int i = 0; i < w * h; i++) order.push_back(i);
        order.shuffle();
        foreach (order[i]) begin
            r = mk(CMD_WRITE, order[i] % w, order[i] / w, $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
            send_request(r);
            // noise: write outside the source
            if ($urandom_range(0, 19) == 0)
                send_request(mk(CMD_WRITE, $urandom_range(w, 511) % 512,
                                $urandom_range(0, 511), $urandom, $urandom, $urandom));
        end
        for (int i = 0; i < n_comp; i++) begin
            r = mk(CMD_COMPUTE, $urandom_range(0, (i % 9 == 0) ? 511 : dw),
                   $urandom_range(0, (i % 7 == 0) ? 511 : dh), $urandom, $urandom,
                   $urandom);
            if (neighbours_loaded(r)) send_request(r);
        end
    endtask

    initial begin
        cycle_cnt = 0; n_errors = 0; rx_stall_en = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_ch.valid = 1'b0; req_ch.data = '0; pix_ch.ready = 1'b0;
        cfg_w = RST_SRC_WIDTH; cfg_h = RST_SRC_HEIGHT;
        cfg_xs = RST_STEP; cfg_ys = RST_STEP;
        foreach (img_set[i]) img_set[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under reset sizes and unit steps
        add_row(mk(CMD_WRITE, 0, 0, 255, 0, 128), 0, '0);
        add_row(mk(CMD_COMPUTE, 0, 0, 0, 0, 0), 1, px_out(255, 0, 128, 0));
        add_row(mk(CMD_WRITE, 511, 511, 1, 2, 3), 0, '0);
        add_row(mk(CMD_COMPUTE, 511, 511, 255, 255, 255), 1, px_out(1, 2, 3, 0));
        add_row(mk(CMD_WRITE, 510, 0, 0, 255, 0), 0, '0);
        add_row(mk(CMD_WRITE, 511, 0, 255, 255, 255), 0, '0);
        add_row(mk(CMD_COMPUTE, 511, 0, 0, 0, 0), 1, px_out(255, 255, 255, 0));
        foreach (dir_tab[i]) begin
            if (dir_tab[i].has_exp && blend_pixel(dir_tab[i].req) != dir_tab[i].exp)
                report_mismatch("table row", i, 0);
            send_request(dir_tab[i].req);
        end
        drain();
        // step of 510.5: blend of 510 and 511 in row 0, then edge clamp on the right
        cfg_write(REG_X_STEP, 32'h1FE8000);
        cfg_write(REG_Y_STEP, 32'h0);
        send_request(mk(CMD_COMPUTE, 1, 0, 0, 0, 0));
        send_request(mk(CMD_COMPUTE, 2, 0, 0, 0, 0));
        drain();
        // width 0 counts as 1; height above the maximum saturates; maximum step
        cfg_write(REG_SRC_WIDTH, 32'h0);
        cfg_write(REG_SRC_HEIGHT, 32'h3FF);
        cfg_write(REG_X_STEP, 32'h1FFFFFF);
        cfg_write(REG_Y_STEP, 32'h1FFFFFF);
        send_request(mk(CMD_WRITE, 0, 0, 9, 8, 7));
        send_request(mk(CMD_WRITE, 0, 1, 200, 100, 50));
        send_request(mk(CMD_COMPUTE, 0, 0, 0, 0, 0));
        send_request(mk(CMD_COMPUTE, 0, 511, 0, 0, 0));
        send_request(mk(CMD_COMPUTE, 511, 1, 0, 0, 0));

        // random phases; the image is reloaded after each size change
        rx_stall_en = 1'b1;
        run_phase(1, 1, 1, 1, 30);
        run_phase(2, 2, 5, 7, 80);
        run_phase(5, 3, 11, 4, 150);
        rx_stall_en = 1'b0;
        run_phase(8, 6, 16, 3, 150);
        rx_stall_en = 1'b1;
        run_phase(16, 9, 7, 20, 200);
        run_phase(3, 12, 1, 30, 120);
        run_phase(20, 20, 37, 25, 250);

        drain();
        if (n_errors == 0 && pixel_q.size() == 0) begin
            $display("[bilinear_image_resize] OK");
        end else begin
            $display("[bilinear_image_resize] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
